>>> rtl/nptf_pkg.sv
// Package for the nearest-point track follower.
// Holds widths shared by the interfaces, the distance unit and the top level.
// No dependencies.
`default_nettype none

package nptf_pkg;

  // Default coordinate width (signed, 8 fractional bits).
  localparam int unsigned COORD_BITS = 24;
  // Frame number width, fixed.
  localparam int unsigned FRAME_BITS = 24;
  // Squared distances saturate at this many bits.
  localparam int unsigned SAT_BITS   = 64;

endpackage : nptf_pkg

`default_nettype wire

>>> rtl/nptf_cand_if.sv
// Candidate channel: valid/ready handshake carrying one 3-D candidate item.
// Depends on nptf_pkg for default widths.
`default_nettype none

interface nptf_cand_if #(
  parameter int unsigned CoordBits = nptf_pkg::COORD_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic signed [CoordBits-1:0]          pos_x;
  logic signed [CoordBits-1:0]          pos_y;
  logic signed [CoordBits-1:0]          pos_z;
  logic        [nptf_pkg::FRAME_BITS-1:0] frame_number;
  logic                                 track_start;
  logic                                 frame_end;

  modport source (
    output valid, pos_x, pos_y, pos_z, frame_number, track_start, frame_end,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, frame_number, track_start, frame_end,
    output ready
  );
endinterface : nptf_cand_if

`default_nettype wire

>>> rtl/nptf_chosen_if.sv
// Result channel: valid/ready handshake carrying the point chosen for a frame.
// Depends on nptf_pkg for default widths.
`default_nettype none

interface nptf_chosen_if #(
  parameter int unsigned CoordBits = nptf_pkg::COORD_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic signed [CoordBits-1:0]          chosen_x;
  logic signed [CoordBits-1:0]          chosen_y;
  logic signed [CoordBits-1:0]          chosen_z;
  logic        [nptf_pkg::FRAME_BITS-1:0] chosen_frame;

  modport source (
    output valid, chosen_x, chosen_y, chosen_z, chosen_frame,
    input  ready
  );
  modport sink (
    input  valid, chosen_x, chosen_y, chosen_z, chosen_frame,
    output ready
  );
endinterface : nptf_chosen_if

`default_nettype wire

>>> rtl/nptf_dist.sv
// Squared Euclidean distance of a candidate to the reference point.
// Three squares in parallel, sum saturating at 64 bits. Uses nptf_pkg.
`default_nettype none

module nptf_dist #(
  parameter int unsigned CoordBits = nptf_pkg::COORD_BITS,
  parameter int unsigned DistBits  = 2 * CoordBits + 2
) (
  input  wire logic signed [CoordBits-1:0] px_i,
  input  wire logic signed [CoordBits-1:0] py_i,
  input  wire logic signed [CoordBits-1:0] pz_i,
  input  wire logic signed [CoordBits-1:0] rx_i,
  input  wire logic signed [CoordBits-1:0] ry_i,
  input  wire logic signed [CoordBits-1:0] rz_i,
  output logic             [DistBits-1:0]  dist_o
);

  localparam int unsigned SqBits  = 2 * CoordBits;
  localparam int unsigned SumBits = SqBits + 2;
  // Wide enough to hold the saturation limit plus one.
  localparam int unsigned ExtBits = (SumBits > nptf_pkg::SAT_BITS) ? SumBits
                                    : nptf_pkg::SAT_BITS + 1;

  logic [CoordBits-1:0] mag_x, mag_y, mag_z;
  logic [SqBits-1:0]    sq_x, sq_y, sq_z;
  logic [ExtBits-1:0]   sum_ext;
  logic [ExtBits-1:0]   sat_lim;

  // |a - b| always fits CoordBits unsigned bits.
  function automatic logic [CoordBits-1:0] abs_diff(
    input logic signed [CoordBits-1:0] a,
    input logic signed [CoordBits-1:0] b
  );
    logic signed [CoordBits:0] d;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    abs_diff = d[CoordBits] ? CoordBits'(-d) : d[CoordBits-1:0];
  endfunction

  always_comb begin
    mag_x   = abs_diff(px_i, rx_i);
    mag_y   = abs_diff(py_i, ry_i);
    mag_z   = abs_diff(pz_i, rz_i);
    sq_x    = SqBits'(mag_x) * SqBits'(mag_x);
    sq_y    = SqBits'(mag_y) * SqBits'(mag_y);
    sq_z    = SqBits'(mag_z) * SqBits'(mag_z);
    sum_ext = ExtBits'(sq_x) + ExtBits'(sq_y) + ExtBits'(sq_z);
    sat_lim = {{(ExtBits - nptf_pkg::SAT_BITS){1'b0}}, {nptf_pkg::SAT_BITS{1'b1}}};
    if (sum_ext > sat_lim) begin
      dist_o = '1;
    end else begin
      dist_o = sum_ext[DistBits-1:0];
    end
  end

endmodule : nptf_dist

`default_nettype wire

>>> rtl/nearest_point_track_follow_top.sv
// Nearest-point track follower, top level.
// A candidate accepted into the input register is evaluated from it in the following cycle;
// a frame's result enters the output register as its frame-end item leaves the input register.
// Throughput: one candidate per cycle; the input stalls only when a frame-end item meets a full,
// unaccepted output register. Reset (rst_ni low, async) empties both stages, zeroes track state.
// Depends on nptf_pkg, nptf_cand_if, nptf_chosen_if and nptf_dist.
`default_nettype none

module nearest_point_track_follow_top #(
  parameter int unsigned COORD_BITS = nptf_pkg::COORD_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nptf_cand_if.sink     cand_i,
  nptf_chosen_if.source chosen_o
);

  // Distance width: full precision, capped at the 64-bit saturation width.
  localparam int unsigned DistBits = (2 * COORD_BITS + 2 > nptf_pkg::SAT_BITS)
                                     ? nptf_pkg::SAT_BITS : 2 * COORD_BITS + 2;
  localparam int unsigned FrameBits = nptf_pkg::FRAME_BITS;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                        s1_valid_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [FrameBits-1:0]        s1_frame_q;
  logic                        s1_start_q, s1_end_q;

  logic in_fire, s1_adv, s1_fire;

  // Track state: reference point, best candidate of the open frame.
  logic signed [COORD_BITS-1:0] ref_x_q, ref_y_q, ref_z_q;
  logic signed [COORD_BITS-1:0] best_x_q, best_y_q, best_z_q;
  logic [FrameBits-1:0]        best_frame_q;
  logic [DistBits-1:0]         best_dist_q;
  logic                        frame_open_q;

  // Output register
  logic                        out_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [FrameBits-1:0]        out_frame_q;

  // A frame-end item may only leave the input register if the output slot is
  // free or being emptied this cycle. Other items never wait.
  assign s1_adv      = !s1_end_q || !out_valid_q || chosen_o.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign cand_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = cand_i.valid && cand_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cand_i.ready) begin
      s1_valid_q <= cand_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q     <= cand_i.pos_x;
      s1_y_q     <= cand_i.pos_y;
      s1_z_q     <= cand_i.pos_z;
      s1_frame_q <= cand_i.frame_number;
      s1_start_q <= cand_i.track_start;
      s1_end_q   <= cand_i.frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluate: distance to reference, take/keep decision
  // ---------------------------------------------------------------------------
  logic [DistBits-1:0] cand_dist;

  nptf_dist #(
    .CoordBits (COORD_BITS),
    .DistBits  (DistBits)
  ) u_dist (
    .px_i   (s1_x_q),
    .py_i   (s1_y_q),
    .pz_i   (s1_z_q),
    .rx_i   (ref_x_q),
    .ry_i   (ref_y_q),
    .rz_i   (ref_z_q),
    .dist_o (cand_dist)
  );

  logic                         take;
  logic [DistBits-1:0]          dist_eff;
  logic signed [COORD_BITS-1:0] best_x_d, best_y_d, best_z_d;
  logic [FrameBits-1:0]         best_frame_d;
  logic [DistBits-1:0]          best_dist_d;

  always_comb begin
    // A track-start candidate counts only when it opens the frame, with
    // distance zero so nothing later in that frame displaces it.
    if (s1_start_q) begin
      dist_eff = '0;
      take     = !frame_open_q;
    end else begin
      dist_eff = cand_dist;
      take     = !frame_open_q || (cand_dist < best_dist_q);
    end
    if (take) begin
      best_x_d     = s1_x_q;
      best_y_d     = s1_y_q;
      best_z_d     = s1_z_q;
      best_frame_d = s1_frame_q;
      best_dist_d  = dist_eff;
    end else begin
      best_x_d     = best_x_q;
      best_y_d     = best_y_q;
      best_z_d     = best_z_q;
      best_frame_d = best_frame_q;
      best_dist_d  = best_dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q      <= '0;
      ref_y_q      <= '0;
      ref_z_q      <= '0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      best_z_q     <= '0;
      best_frame_q <= '0;
      best_dist_q  <= '0;
      frame_open_q <= 1'b0;
    end else if (s1_fire) begin
      best_x_q     <= best_x_d;
      best_y_q     <= best_y_d;
      best_z_q     <= best_z_d;
      best_frame_q <= best_frame_d;
      best_dist_q  <= best_dist_d;
      if (s1_end_q) begin
        // Chosen point becomes the reference for the next frame.
        ref_x_q      <= best_x_d;
        ref_y_q      <= best_y_d;
        ref_z_q      <= best_z_d;
        frame_open_q <= 1'b0;
      end else begin
        frame_open_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = s1_fire && s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (chosen_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q     <= best_x_d;
      out_y_q     <= best_y_d;
      out_z_q     <= best_z_d;
      out_frame_q <= best_frame_d;
    end
  end

  assign chosen_o.valid        = out_valid_q;
  assign chosen_o.chosen_x     = out_x_q;
  assign chosen_o.chosen_y     = out_y_q;
  assign chosen_o.chosen_z     = out_z_q;
  assign chosen_o.chosen_frame = out_frame_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Emitting a frame closes it.
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !frame_open_q)
    else $error("frame still open after its result was loaded");

  // A new result only appears after a frame-end item was evaluated.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_load))
    else $error("output became valid without a frame-end item");

  // A track-start candidate inside an open frame never changes the best.
  a_start_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_start_q && frame_open_q |=>
      $stable(best_dist_q) && $stable(best_frame_q))
    else $error("late track-start candidate replaced the best one");

  // A held frame-end item never overwrites an unaccepted result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !chosen_o.ready |-> !out_load)
    else $error("pending result overwritten");

endmodule : nearest_point_track_follow_top

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for the nearest-point track follower.
// Depends on nptf_pkg, nptf_cand_if, nptf_chosen_if and nearest_point_track_follow_top.
// A queued driver feeds candidates and a local predictor; results go to a clocked monitor.
`default_nettype none

module tb;

  localparam int unsigned CB = nptf_pkg::COORD_BITS;
  localparam int unsigned FB = nptf_pkg::FRAME_BITS;

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [FB-1:0]        FMAX = '1;

  // random candidate items after the directed frames
  localparam int unsigned RAND_ITEMS = 1300;
  // cycles to wait after the last result
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic [FB-1:0]        frame;
    logic                 start;
    logic                 last;
  } cand_item_t;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic [FB-1:0]        frame;
  } chosen_pt_t;

  logic clk_i;
  logic rst_ni;

  nptf_cand_if   #(.CoordBits(CB)) cand   ();
  nptf_chosen_if #(.CoordBits(CB)) chosen ();

  nearest_point_track_follow_top #(.COORD_BITS(CB)) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cand_i   (cand),
    .chosen_o (chosen)
  );

  // ---------------------------------------------------------------------------
  // Stimulus queue and expected results
  // ---------------------------------------------------------------------------
  cand_item_t cand_pend[$];    // candidates not yet presented
  chosen_pt_t chosen_q[$];     // chosen points still owed by the block

  int unsigned n_total;        // candidates queued in total
  int unsigned n_sent;         // candidates accepted
  int unsigned n_frames;       // frames closed by the predictor
  int unsigned n_checked;      // chosen points compared
  int unsigned n_err;

  // ---------------------------------------------------------------------------
  // Predictor state: the point picked for the previous frame (the anchor) and
  // the leader of the frame that is currently open.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] anchor_x = '0, anchor_y = '0, anchor_z = '0;
  logic signed [CB-1:0] lead_x = '0, lead_y = '0, lead_z = '0;
  logic [FB-1:0]        lead_frame = '0;
  logic [63:0]          lead_dist = '0;
  logic                 frame_busy = 1'b0;

  // squared distance along one axis, exact up to 32-bit coordinates
  function automatic logic [63:0] axis_sq(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    logic [CB:0]        m;
    logic [63:0]        w;
    d = a - b;
    m = d[CB] ? -d : d;
    w = m;
    return w * w;
  endfunction

  // full squared distance to the anchor, clamped to 64 bits
  function automatic logic [63:0] anchor_dist(cand_item_t c);
    logic [65:0] s;
    s = {2'b00, axis_sq(c.x, anchor_x)} + {2'b00, axis_sq(c.y, anchor_y)}
        + {2'b00, axis_sq(c.z, anchor_z)};
    return (s > 66'hFFFF_FFFF_FFFF_FFFF) ? '1 : s[63:0];
  endfunction

  // Advance the predictor by one accepted candidate.
  task automatic follow_step(cand_item_t c);
    logic [63:0] d;
    logic        take;
    chosen_pt_t  pt;
    if (c.start) begin
      // track start: only wins if it opens the frame, then it cannot be beaten
      d    = '0;
      take = !frame_busy;
    end else begin
      d    = anchor_dist(c);
      take = !frame_busy || (d < lead_dist);   // strict: ties keep the earlier one
    end
    if (take) begin
      lead_x     = c.x;
      lead_y     = c.y;
      lead_z     = c.z;
      lead_frame = c.frame;
      lead_dist  = d;
    end
    frame_busy = 1'b1;
    if (c.last) begin
      pt.x     = lead_x;
      pt.y     = lead_y;
      pt.z     = lead_z;
      pt.frame = lead_frame;
      chosen_q = {chosen_q, pt};
      anchor_x   = lead_x;
      anchor_y   = lead_y;
      anchor_z   = lead_z;
      frame_busy = 1'b0;
      n_frames++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_cand(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                          logic signed [CB-1:0] z, logic [FB-1:0] frame,
                          logic start, logic last);
    cand_item_t c;
    c.x = x; c.y = y; c.z = z;
    c.frame = frame; c.start = start; c.last = last;
    cand_pend = {cand_pend, c};
  endtask

  // mostly close to the track center, sometimes anywhere or at an extreme
  function automatic logic signed [CB-1:0] coord_near(logic signed [CB-1:0] c);
    int off;
    off = int'($urandom_range(0, 1023)) - 512;
    case ($urandom_range(0, 19))
      0:          return CMAX;
      1:          return CMIN;
      2:          return '0;
      3:          return '1;
      4, 5, 6, 7: return CB'($urandom);
      default:    return CB'(c + off);
    endcase
  endfunction

  // Frames of random size around a slowly wandering center; a few frames open
  // a new track, a few candidates carry a stray start flag or frame number,
  // and some repeat the previous candidate to force exact ties.
  task automatic gen_tracks(int unsigned n_items);
    logic signed [CB-1:0] cx, cy, cz, px, py, pz;
    logic [FB-1:0]        fr;
    logic                 st;
    int unsigned          n, len, k;
    cx = CB'($urandom); cy = CB'($urandom); cz = CB'($urandom);
    px = '0; py = '0; pz = '0;
    fr = FB'($urandom);
    n  = 0;
    while (n < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      st  = ($urandom_range(0, 7) == 0);
      if (st) begin
        cx = CB'($urandom); cy = CB'($urandom); cz = CB'($urandom);
      end else begin
        cx = coord_near(cx); cy = coord_near(cy); cz = coord_near(cz);
      end
      fr = ($urandom_range(0, 15) == 0) ? FB'($urandom) : fr + 1'b1;
      for (k = 0; k < len; k++) begin
        if (k == 0 || $urandom_range(0, 9) != 0) begin
          px = coord_near(cx); py = coord_near(cy); pz = coord_near(cz);
        end
        add_cand(px, py, pz,
                 ($urandom_range(0, 19) == 0) ? FB'($urandom) : fr,
                 st ^ ($urandom_range(0, 19) == 0),
                 k == len - 1);
      end
      n += len;
    end
  endtask

  // Gap length per item; now and then a run of items with no gap at all.
  task automatic draw_pause(inout int unsigned calm, output int unsigned len);
    if (calm != 0) begin
      calm--;
      len = 0;
    end else begin
      if ($urandom_range(0, 31) == 0) calm = $urandom_range(20, 60);
      len = $urandom_range(0, 11);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Candidate driver: presents queued items, waits a drawn gap after each
  // accepted one. The predictor is advanced on every handshake.
  // ---------------------------------------------------------------------------
  cand_item_t  cand_cur;
  logic        vld_nxt;
  int unsigned src_wait, src_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand.valid <= 1'b0;
      src_wait = 0;
      src_calm = 0;
    end else begin
      vld_nxt = cand.valid;
      if (cand.valid && cand.ready) begin
        follow_step(cand_cur);
        n_sent++;
        vld_nxt = 1'b0;
      end
      if (!vld_nxt) begin
        if (src_wait != 0) begin
          src_wait--;
        end else if (cand_pend.size() != 0) begin
          cand_cur = cand_pend.pop_front();
          cand.pos_x        <= cand_cur.x;
          cand.pos_y        <= cand_cur.y;
          cand.pos_z        <= cand_cur.z;
          cand.frame_number <= cand_cur.frame;
          cand.track_start  <= cand_cur.start;
          cand.frame_end    <= cand_cur.last;
          vld_nxt = 1'b1;
          draw_pause(src_calm, src_wait);
        end
      end
      // one assignment per edge so a back-to-back item keeps valid high
      cand.valid <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: may hold ready low for a drawn pause after each item,
  // compares every accepted chosen point with the oldest expectation.
  // ---------------------------------------------------------------------------
  chosen_pt_t  want;
  logic        rdy_nxt;
  int unsigned snk_wait, snk_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chosen.ready <= 1'b0;
      snk_wait = 0;
      snk_calm = 0;
    end else begin
      rdy_nxt = chosen.ready;
      if (chosen.valid && chosen.ready) begin
        if (chosen_q.size() == 0) begin
          $error("chosen point with nothing pending: x %0d y %0d z %0d frame %0d",
                 chosen.chosen_x, chosen.chosen_y, chosen.chosen_z, chosen.chosen_frame);
          n_err++;
        end else begin
          want = chosen_q.pop_front();
          n_checked++;
          if (chosen.chosen_x !== want.x) begin
            $error("chosen_x: expected %0d, got %0d", want.x, chosen.chosen_x);
            n_err++;
          end
          if (chosen.chosen_y !== want.y) begin
            $error("chosen_y: expected %0d, got %0d", want.y, chosen.chosen_y);
            n_err++;
          end
          if (chosen.chosen_z !== want.z) begin
            $error("chosen_z: expected %0d, got %0d", want.z, chosen.chosen_z);
            n_err++;
          end
          if (chosen.chosen_frame !== want.frame) begin
            $error("chosen_frame: expected %0d, got %0d", want.frame, chosen.chosen_frame);
            n_err++;
          end
        end
        draw_pause(snk_calm, snk_wait);
        rdy_nxt = (snk_wait == 0);
      end else if (!chosen.ready) begin
        if (snk_wait != 0) snk_wait--;
        if (snk_wait == 0) rdy_nxt = 1'b1;
      end
      chosen.ready <= rdy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    n_total = 0; n_sent = 0; n_frames = 0; n_checked = 0; n_err = 0;
    rst_ni            = 1'b0;
    cand.valid        = 1'b0;
    cand.pos_x        = '0;
    cand.pos_y        = '0;
    cand.pos_z        = '0;
    cand.frame_number = '0;
    cand.track_start  = 1'b0;
    cand.frame_end    = 1'b0;
    chosen.ready      = 1'b0;

    // No track start yet, anchor at the origin: second candidate is closer,
    // third ties with it and must lose.
    add_cand(3, -2, 1, '0, 1'b0, 1'b0);
    add_cand(0, 0, -1, '0, 1'b0, 1'b0);
    add_cand(1, 0, 0, '0, 1'b0, 1'b1);
    // Single-candidate frame at the positive corner, largest frame number.
    add_cand(CMAX, CMAX, CMAX, FMAX, 1'b0, 1'b1);
    // Opposite corner first (largest possible distance), then a one-step
    // neighbor wins, two more one-step neighbors tie and lose.
    add_cand(CMIN, CMIN, CMIN, FB'(1), 1'b0, 1'b0);
    add_cand(CMAX - 1'b1, CMAX, CMAX, FB'(2), 1'b0, 1'b0);
    add_cand(CMAX, CMAX - 1'b1, CMAX, FB'(3), 1'b0, 1'b0);
    add_cand(CMAX, CMAX, CMAX - 1'b1, FB'(4), 1'b0, 1'b1);
    // Track start: the first candidate is taken even though it is far away;
    // a second start candidate and an exact hit on the anchor both lose.
    add_cand(CMIN, 0, 5, FB'(5), 1'b1, 1'b0);
    add_cand(CMAX - 1'b1, CMAX, CMAX, FB'(6), 1'b1, 1'b0);
    add_cand(CMAX - 1'b1, CMAX, CMAX, FB'(7), 1'b0, 1'b1);
    // Frame opened by a normal candidate: a late start candidate on the anchor
    // is not taken.
    add_cand(0, 0, 0, FB'(8), 1'b0, 1'b0);
    add_cand(CMIN, 0, 5, FB'(9), 1'b1, 1'b1);
    // Start and end on the same candidate.
    add_cand('1, '1, '1, '0, 1'b1, 1'b1);

    gen_tracks(RAND_ITEMS);
    n_total = cand_pend.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all candidates accepted and every chosen point returned
    do @(posedge clk_i);
    while (n_sent != n_total || chosen_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d candidates in %0d frames, incl. extremes, ties and track starts",
             n_sent, n_frames);
    $display("run: %0d chosen points compared, %0d mismatches", n_checked, n_err);
    if (n_err == 0 && chosen_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule : tb

`default_nettype wire

>>> filelist.f
rtl/nptf_pkg.sv
rtl/nptf_cand_if.sv
rtl/nptf_chosen_if.sv
rtl/nptf_dist.sv
rtl/nearest_point_track_follow_top.sv
tb/tb.sv
